// ----- rtl/core/event_fragment_deframer_defines.svh -----
// Assertion macros shared by the event fragment deframer modules.
// Needs clk and arst_n in the scope of each use.
`ifndef EVENT_FRAGMENT_DEFRAMER_DEFINES_SVH
`define EVENT_FRAGMENT_DEFRAMER_DEFINES_SVH

// property checked at every clock edge outside reset
`define EFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression that must never be true outside reset
`define EFD_ASSERT_NEVER(label, expr, msg) \
	`EFD_ASSERT(label, !(expr), msg)

`endif

// ----- rtl/core/efd_pkg.sv -----
// Types and constants of the event fragment deframer.
// Used by efd_front, efd_cmd_fifo, efd_back and event_fragment_deframer.
`default_nettype none

package efd_pkg;

	localparam int unsigned CmdDepth = 4;
	localparam int unsigned CmdAw    = $clog2(CmdDepth);

	localparam logic [15:0] END_MARK = 16'hE0DA;

	// word positions inside the header
	localparam logic [2:0] POS_RUN   = 3'd2;
	localparam logic [2:0] POS_L1ID  = 3'd3;
	localparam logic [2:0] POS_BCID  = 3'd4;
	localparam logic [2:0] POS_TTYPE = 3'd5;
	localparam logic [2:0] POS_ETYPE = 3'd6;
	localparam logic [2:0] POS_HDR_FIRST = 3'd1;

	// word positions inside the trailer
	localparam logic [2:0] POS_TR_ID    = 3'd0;
	localparam logic [2:0] POS_TR_FLAGS = 3'd1;
	localparam logic [2:0] POS_TR_RESV  = 3'd2;
	localparam logic [2:0] POS_TR_LAST  = 3'd3;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_TRUNC   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PAYLOAD,
		PH_TRAILER
	} phase_t;

	// what closes a command after its optional payload word
	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_SUMMARY,
		TAIL_TRUNC
	} tail_t;

	typedef struct packed {
		logic [31:0] run;
		logic [31:0] l1id;
		logic [11:0] bcid;
		logic [7:0]  ttype;
		logic [7:0]  etype;
		logic [3:0]  tim;
	} hdr_t;

	typedef struct packed {
		logic        has_pay;
		tail_t       tail;
		logic [31:0] word;
		hdr_t        hdr;
		logic [31:0] trail_id;
		logic [31:0] flags;
		logic [31:0] resv;
		logic        mismatch;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/efd_cmd_fifo.sv -----
// Short command queue between the front parser and the result back end.
// Depends on efd_pkg and the assertion macros.
`default_nettype none
`include "event_fragment_deframer_defines.svh"

module efd_cmd_fifo import efd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_cmd,
	output logic      full,
	input  wire logic rd_en,
	output cmd_t      rd_cmd,
	output logic      rd_valid
);

	cmd_t             slots_q [CmdDepth];
	logic [CmdAw-1:0] wr_ptr_q;
	logic [CmdAw-1:0] rd_ptr_q;
	logic [CmdAw:0]   count_q;

	assign full     = (count_q == (CmdAw+1)'(CmdDepth));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`EFD_ASSERT_NEVER(a_no_write_full, wr_en && full, "command written into full queue")
	`EFD_ASSERT_NEVER(a_no_read_empty, rd_en && !rd_valid, "command taken from empty queue")
	`EFD_ASSERT_NEVER(a_count_range, count_q > (CmdAw+1)'(CmdDepth), "queue count overflow")

endmodule

`default_nettype wire

// ----- rtl/core/efd_front.sv -----
// Front end: tracks fragment position, captures header and trailer words,
// and turns payload words and fragment ends into result commands. Depends on efd_pkg.
`default_nettype none

module efd_front import efd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [31:0] word,
	input  wire logic        start_req,
	input  wire logic        final_req,
	output logic             cmd_push,
	output cmd_t             cmd
);

	phase_t      phase_q, phase_d;
	logic [2:0]  pos_q, pos_d;
	hdr_t        hdr_q, hdr_d;
	logic [31:0] trail_id_q, trail_id_d;
	logic [31:0] flags_q, flags_d;
	logic [31:0] resv_q, resv_d;
	logic        has_pay;
	tail_t       tail;
	logic        open_word;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		hdr_d      = hdr_q;
		trail_id_d = trail_id_q;
		flags_d    = flags_q;
		resv_d     = resv_q;
		has_pay    = 1'b0;
		tail       = TAIL_NONE;
		open_word  = 1'b1;

		if (start_req) begin
			// a start abandons any open fragment
			hdr_d      = '0;
			trail_id_d = '0;
			flags_d    = '0;
			resv_d     = '0;
			phase_d    = PH_HEADER;
			pos_d      = POS_HDR_FIRST;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					open_word = 1'b0;
				end
				PH_HEADER: begin
					unique case (pos_q)
						POS_RUN:   hdr_d.run   = word;
						POS_L1ID:  hdr_d.l1id  = word;
						POS_BCID:  hdr_d.bcid  = word[11:0];
						POS_TTYPE: hdr_d.ttype = word[7:0];
						POS_ETYPE: begin
							hdr_d.etype = word[23:16];
							hdr_d.tim   = word[3:0];
						end
						default: ;
					endcase
					if (pos_q >= POS_ETYPE) begin
						phase_d = PH_PAYLOAD;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					if (word[31:16] == END_MARK) begin
						phase_d = PH_TRAILER;
						pos_d   = POS_TR_ID;
					end else begin
						has_pay = 1'b1;
					end
				end
				PH_TRAILER: begin
					unique case (pos_q)
						POS_TR_ID:    trail_id_d = word;
						POS_TR_FLAGS: flags_d    = word;
						POS_TR_RESV:  resv_d     = word;
						default: ;
					endcase
					if (pos_q >= POS_TR_LAST) begin
						tail      = TAIL_SUMMARY;
						open_word = 1'b0;
						phase_d   = PH_IDLE;
						pos_d     = '0;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end
				default: ;
			endcase
		end

		// early end; the last trailer word ignores final_req
		if (final_req && open_word) begin
			tail    = TAIL_TRUNC;
			phase_d = PH_IDLE;
			pos_d   = '0;
		end
	end

	assign cmd_push     = accept && (has_pay || tail != TAIL_NONE);
	assign cmd.has_pay  = has_pay;
	assign cmd.tail     = tail;
	assign cmd.word     = word;
	assign cmd.hdr      = hdr_d;
	assign cmd.trail_id = trail_id_d;
	assign cmd.flags    = flags_d;
	assign cmd.resv     = resv_d;
	assign cmd.mismatch = (trail_id_d != hdr_d.l1id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= '0;
			hdr_q      <= '0;
			trail_id_q <= '0;
			flags_q    <= '0;
			resv_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			hdr_q      <= hdr_d;
			trail_id_q <= trail_id_d;
			flags_q    <= flags_d;
			resv_q     <= resv_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/efd_back.sv -----
// Back end: expands queued commands into result words held in the output
// register. Depends on efd_pkg and the assertion macros.
`default_nettype none
`include "event_fragment_deframer_defines.svh"

module efd_back import efd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire logic        cmd_valid,
	output logic             cmd_pop,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [31:0]      data_word,
	output logic [31:0]      run_number,
	output logic [31:0]      header_l1id,
	output logic [11:0]      bunch_crossing,
	output logic [7:0]       trigger_type,
	output logic [7:0]       event_type,
	output logic [3:0]       timing_bits,
	output logic [31:0]      event_flags,
	output logic [31:0]      reserved_word,
	output logic [31:0]      last_trailer_word,
	output logic             id_mismatch
);

	logic        out_valid_q;
	logic        sub_q;     // payload part of the head command already sent
	kind_t       kind_q;
	logic [31:0] data_q;
	hdr_t        hdr_q;
	logic [31:0] flags_q;
	logic [31:0] resv_q;
	logic [31:0] last_q;
	logic        mis_q;

	logic        load;
	logic        send_pay;
	kind_t       nxt_kind;
	logic [31:0] nxt_data;
	logic        is_sum;

	assign load     = !out_valid_q || pop;
	assign send_pay = cmd.has_pay && !sub_q;
	assign is_sum   = !send_pay && cmd.tail == TAIL_SUMMARY;
	assign cmd_pop  = load && cmd_valid && (!send_pay || cmd.tail == TAIL_NONE);

	always_comb begin
		if (send_pay) begin
			nxt_kind = KIND_PAYLOAD;
			nxt_data = cmd.word;
		end else if (cmd.tail == TAIL_SUMMARY) begin
			nxt_kind = KIND_SUMMARY;
			nxt_data = cmd.trail_id;
		end else begin
			nxt_kind = KIND_TRUNC;
			nxt_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= cmd_valid;
			if (cmd_valid) begin
				sub_q <= send_pay && cmd.tail != TAIL_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			kind_q  <= nxt_kind;
			data_q  <= nxt_data;
			hdr_q   <= cmd.hdr;
			flags_q <= is_sum ? cmd.flags : '0;
			resv_q  <= is_sum ? cmd.resv : '0;
			last_q  <= is_sum ? cmd.word : '0;
			mis_q   <= is_sum && cmd.mismatch;
		end
	end

	assign empty             = !out_valid_q;
	assign kind              = kind_q;
	assign data_word         = data_q;
	assign run_number        = hdr_q.run;
	assign header_l1id       = hdr_q.l1id;
	assign bunch_crossing    = hdr_q.bcid;
	assign trigger_type      = hdr_q.ttype;
	assign event_type        = hdr_q.etype;
	assign timing_bits       = hdr_q.tim;
	assign event_flags       = flags_q;
	assign reserved_word     = resv_q;
	assign last_trailer_word = last_q;
	assign id_mismatch       = mis_q;

	`EFD_ASSERT(a_sub_has_tail, sub_q |-> (cmd_valid && cmd.has_pay && cmd.tail != TAIL_NONE),
		"split command lost its closing result")
	`EFD_ASSERT(a_sub_sends_tail, (load && sub_q) |=> (kind_q != KIND_PAYLOAD),
		"payload word sent twice")
	`EFD_ASSERT(a_hold_result, (out_valid_q && !pop) |=> out_valid_q,
		"waiting result dropped")

endmodule

`default_nettype wire

// ----- rtl/core/event_fragment_deframer.sv -----
// Event fragment deframer, top level.
// Instantiates efd_front, efd_cmd_fifo and efd_back; depends on efd_pkg.
//
// Input side is a queue write port: word, start_req and final_req are taken
// at a clock edge with push high and full low. Results come out of a queue
// read port: while empty is low the oldest result sits on kind, data_word
// and the header/trailer fields, and pop with empty low takes it.
// One word is accepted per cycle while full is low. Header, marker and idle
// words give no result; a payload word gives one, a word that ends a fragment
// early gives a payload word (if any) followed by a truncated result, and the
// last trailer word gives the summary.
// A result is registered in the command queue and then in the output register.
// Throughput: one word per cycle while full is low; the output register sends
// one result per cycle while pop keeps up, and a 4-entry command queue between
// parser and output absorbs words with two results and short stalls.
// When the receiver holds off pop, the queue fills and full rises; the
// parser then waits with its state intact.
// Reset (arst_n low) empties the queue and output, and the parser waits for
// a start word; words without start_req before that are dropped.
`default_nettype none

module event_fragment_deframer import efd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] word,
	input  wire logic        start_req,
	input  wire logic        final_req,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [31:0]      data_word,
	output logic [31:0]      run_number,
	output logic [31:0]      header_l1id,
	output logic [11:0]      bunch_crossing,
	output logic [7:0]       trigger_type,
	output logic [7:0]       event_type,
	output logic [3:0]       timing_bits,
	output logic [31:0]      event_flags,
	output logic [31:0]      reserved_word,
	output logic [31:0]      last_trailer_word,
	output logic             id_mismatch
);

	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_valid;
	logic cmd_pop;

	assign accept = push && !full;

	efd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.word      (word),
		.start_req (start_req),
		.final_req (final_req),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	efd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_cmd   (cmd_in),
		.full     (full),
		.rd_en    (cmd_pop),
		.rd_cmd   (cmd_head),
		.rd_valid (cmd_valid)
	);

	efd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd_head),
		.cmd_valid         (cmd_valid),
		.cmd_pop           (cmd_pop),
		.pop               (pop),
		.empty             (empty),
		.kind              (kind),
		.data_word         (data_word),
		.run_number        (run_number),
		.header_l1id       (header_l1id),
		.bunch_crossing    (bunch_crossing),
		.trigger_type      (trigger_type),
		.event_type        (event_type),
		.timing_bits       (timing_bits),
		.event_flags       (event_flags),
		.reserved_word     (reserved_word),
		.last_trailer_word (last_trailer_word),
		.id_mismatch       (id_mismatch)
	);

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for event_fragment_deframer.
// Needs efd_pkg and the deframer RTL; runs a directed table, then random fragments,
// and checks every popped result against a built-in fragment parser.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import efd_pkg::*;

	localparam int NUM_WORDS = 850;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_SILENT,
		CHK_BARE_TRUNC
	} row_chk_t;

	typedef struct packed {
		logic [31:0] w;
		logic        s;
		logic        f;
		row_chk_t    chk;
	} stim_row_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] data;
		hdr_t        hdr;
		logic [31:0] flags;
		logic [31:0] resv;
		logic [31:0] last;
		logic        mis;
	} frag_res_t;

	// rows marked silent or bare-trunc carry their own expectation
	localparam stim_row_t DIRECTED_ROWS [27] = '{
		'{32'h0000_0000, 1'b0, 1'b1, CHK_SILENT},      // idle after reset, dropped
		'{32'hFFFF_FFFF, 1'b1, 1'b1, CHK_BARE_TRUNC},  // end on the start word
		'{32'hFFFF_FFFF, 1'b1, 1'b0, CHK_SILENT},
		'{32'h0000_0000, 1'b0, 1'b0, CHK_SILENT},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_SILENT},      // run
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_SILENT},      // l1id
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_SILENT},      // bcid
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_SILENT},      // trigger type
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_SILENT},      // event type / timing
		'{32'h0000_0000, 1'b0, 1'b0, CHK_PREDICT},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_PREDICT},
		'{32'hE0DA_0000, 1'b0, 1'b0, CHK_SILENT},      // end marker
		'{32'h0000_0000, 1'b0, 1'b0, CHK_SILENT},      // trailer id differs
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_SILENT},
		'{32'hFFFF_FFFF, 1'b0, 1'b0, CHK_SILENT},
		'{32'h0000_0000, 1'b0, 1'b1, CHK_PREDICT},     // last trailer word, end flag moot
		'{32'h1234_5678, 1'b0, 1'b1, CHK_SILENT},      // idle after summary
		'{32'h0000_0000, 1'b1, 1'b0, CHK_SILENT},
		'{32'h8000_0001, 1'b0, 1'b0, CHK_SILENT},
		'{32'h0000_0000, 1'b1, 1'b0, CHK_SILENT},      // restart abandons open fragment
		'{32'h5555_5555, 1'b0, 1'b0, CHK_SILENT},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, CHK_SILENT},
		'{32'h0000_0001, 1'b0, 1'b0, CHK_SILENT},
		'{32'h0000_0ABC, 1'b0, 1'b0, CHK_SILENT},
		'{32'h0000_0081, 1'b0, 1'b0, CHK_SILENT},
		'{32'h00C3_0009, 1'b0, 1'b0, CHK_SILENT},
		'{32'hE0DB_FFFF, 1'b0, 1'b1, CHK_PREDICT}      // payload then truncation
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] word = '0;
	logic        start_req = 1'b0;
	logic        final_req = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [31:0] data_word;
	logic [31:0] run_number;
	logic [31:0] header_l1id;
	logic [11:0] bunch_crossing;
	logic [7:0]  trigger_type;
	logic [7:0]  event_type;
	logic [3:0]  timing_bits;
	logic [31:0] event_flags;
	logic [31:0] reserved_word;
	logic [31:0] last_trailer_word;
	logic        id_mismatch;

	row_chk_t cur_chk = CHK_PREDICT;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// parser state
	phase_t      frag_phase = PH_IDLE;
	logic [2:0]  frag_pos = '0;
	hdr_t        hdr_q = '0;
	logic [31:0] tr_id_q = '0;
	logic [31:0] tr_flags_q = '0;
	logic [31:0] tr_resv_q = '0;
	bit          word_ignored;
	frag_res_t   step_res[$];
	frag_res_t   pending_res[$];

	int errors = 0;
	int words_taken = 0;
	int words_dropped = 0;
	int n_payload = 0;
	int n_summary = 0;
	int n_trunc = 0;

	event_fragment_deframer i_dut (.*);

	always #2 clk = ~clk;

	function automatic void add_result(kind_t k, logic [31:0] d, logic [31:0] fl,
			logic [31:0] rs, logic [31:0] lw, logic m);
		frag_res_t r;
		r.kind  = k;
		r.data  = d;
		r.hdr   = hdr_q;
		r.flags = fl;
		r.resv  = rs;
		r.last  = lw;
		r.mis   = m;
		step_res = {step_res, r};
	endfunction

	// one accepted word through the fragment parser; results land in step_res
	function automatic void deframe_word(logic [31:0] w, logic s, logic f);
		step_res.delete();
		word_ignored = 1'b0;
		if (s) begin
			hdr_q      = '0;
			tr_id_q    = '0;
			tr_flags_q = '0;
			tr_resv_q  = '0;
			frag_phase = PH_HEADER;
			frag_pos   = POS_HDR_FIRST;
		end else if (frag_phase == PH_IDLE) begin
			word_ignored = 1'b1;
			return;
		end else if (frag_phase == PH_HEADER) begin
			case (frag_pos)
				POS_RUN:   hdr_q.run = w;
				POS_L1ID:  hdr_q.l1id = w;
				POS_BCID:  hdr_q.bcid = w[11:0];
				POS_TTYPE: hdr_q.ttype = w[7:0];
				POS_ETYPE: begin
					hdr_q.etype = w[23:16];
					hdr_q.tim   = w[3:0];
				end
				default: ;
			endcase
			if (frag_pos >= POS_ETYPE) begin
				frag_phase = PH_PAYLOAD;
				frag_pos   = '0;
			end else begin
				frag_pos = frag_pos + 3'd1;
			end
		end else if (frag_phase == PH_PAYLOAD) begin
			if (w[31:16] == END_MARK) begin
				frag_phase = PH_TRAILER;
				frag_pos   = POS_TR_ID;
			end else begin
				add_result(KIND_PAYLOAD, w, '0, '0, '0, 1'b0);
			end
		end else begin
			case (frag_pos)
				POS_TR_ID:    tr_id_q = w;
				POS_TR_FLAGS: tr_flags_q = w;
				POS_TR_RESV:  tr_resv_q = w;
				default: ;
			endcase
			if (frag_pos >= POS_TR_LAST) begin
				// the end flag is moot on the last trailer word
				add_result(KIND_SUMMARY, tr_id_q, tr_flags_q, tr_resv_q, w,
					tr_id_q != hdr_q.l1id);
				frag_phase = PH_IDLE;
				frag_pos   = '0;
				return;
			end
			frag_pos = frag_pos + 3'd1;
		end
		if (f) begin
			add_result(KIND_TRUNC, '0, '0, '0, '0, 1'b0);
			frag_phase = PH_IDLE;
			frag_pos   = '0;
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
			errors++;
		end
	endfunction

	// output side first, so a result can never match a word taken at the same edge
	always @(posedge clk) begin
		frag_res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_res.size() == 0) begin
				$error("unexpected result: kind %0d data_word 0x%0h", kind, data_word);
				errors++;
			end else begin
				want = pending_res.pop_front();
				case (want.kind)
					KIND_PAYLOAD: n_payload++;
					KIND_SUMMARY: n_summary++;
					default:      n_trunc++;
				endcase
				check_field("kind", want.kind, kind);
				check_field("data_word", want.data, data_word);
				check_field("run_number", want.hdr.run, run_number);
				check_field("header_l1id", want.hdr.l1id, header_l1id);
				check_field("bunch_crossing", want.hdr.bcid, bunch_crossing);
				check_field("trigger_type", want.hdr.ttype, trigger_type);
				check_field("event_type", want.hdr.etype, event_type);
				check_field("timing_bits", want.hdr.tim, timing_bits);
				check_field("event_flags", want.flags, event_flags);
				check_field("reserved_word", want.resv, reserved_word);
				check_field("last_trailer_word", want.last, last_trailer_word);
				check_field("id_mismatch", want.mis, id_mismatch);
			end
		end
		if (arst_n && push && !full) begin
			deframe_word(word, start_req, final_req);
			if (word_ignored)
				words_dropped++;
			else
				words_taken++;
			case (cur_chk)
				CHK_SILENT: step_res.delete();
				CHK_BARE_TRUNC: begin
					step_res.delete();
					want = '0;
					want.kind = KIND_TRUNC;
					step_res = {step_res, want};
				end
				default: ;
			endcase
			foreach (step_res[k])
				pending_res = {pending_res, step_res[k]};
		end
	end

	always @(negedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(logic [31:0] w, logic s, logic f, row_chk_t c);
		int gap;
		gap = 0;
		while (gap < 12 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		word      <= w;
		start_req <= s;
		final_req <= f;
		cur_chk   <= c;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly well-formed fragments; some end early or get abandoned by a restart
	task automatic send_fragment();
		int n_pay;
		int last_idx;
		int cut_at;
		int drop_at;
		logic [31:0] l1;
		logic [31:0] w;
		logic f;
		n_pay    = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(4);
		last_idx = 11 + n_pay;
		cut_at   = ($urandom_range(5) == 0) ? $urandom_range(last_idx) : -1;
		drop_at  = ($urandom_range(9) == 0) ? $urandom_range(last_idx, 1) : -1;
		l1       = $urandom;
		for (int i = 0; i <= last_idx; i++) begin
			if (i == drop_at)
				break;
			w = $urandom;
			if (i == 3) begin
				w = l1;
			end else if (i >= 7 && i < 7 + n_pay) begin
				if ($urandom_range(9) == 0)
					w[31:16] = END_MARK ^ (16'd1 << $urandom_range(15));
				else if (w[31:16] == END_MARK)
					w[16] = ~w[16];
			end else if (i == 7 + n_pay) begin
				w[31:16] = END_MARK;
			end else if (i == 8 + n_pay && $urandom_range(1)) begin
				w = l1;
			end
			f = (i == cut_at) || (i == last_idx && $urandom_range(3) == 0);
			send_word(w, i == 0, f, CHK_PREDICT);
			if (i == cut_at)
				break;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[r])
			send_word(DIRECTED_ROWS[r].w, DIRECTED_ROWS[r].s, DIRECTED_ROWS[r].f,
				DIRECTED_ROWS[r].chk);

		while (words_taken < NUM_WORDS) begin
			case (words_taken * 4 / NUM_WORDS)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 58; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 58; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			// stray words between fragments, usually dropped by the parser
			if ($urandom_range(6) == 0)
				repeat ($urandom_range(3, 1))
					send_word($urandom, 1'b0, 1'($urandom_range(1)), CHK_PREDICT);
			send_fragment();
		end

		push <= 1'b0;
		stall_pct = 0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d fragment words taken, %0d stray words dropped", words_taken,
			words_dropped);
		$display("results checked: %0d payload, %0d summary, %0d truncated", n_payload,
			n_summary, n_trunc);
		if (errors == 0)
			$display("event_fragment_deframer regression: pass");
		else
			$display("event_fragment_deframer regression: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("event_fragment_deframer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/efd_pkg.sv
rtl/core/efd_cmd_fifo.sv
rtl/core/efd_front.sv
rtl/core/efd_back.sv
rtl/core/event_fragment_deframer.sv
dv/tb.sv
